@@ src/pcm_pkg.sv @@
package pcm_pkg;

  // Palette geometry.
  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // Fixed field widths.
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned ENTRY_W = 3 * COLOR_W;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned SQ_W    = 2 * COLOR_W;
  localparam int unsigned DIST_W  = 18;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);
  localparam logic [DIST_W-1:0]  DIST_START  = DIST_W'(3 * 256 * 256);

  // Request modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_MAP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic load;
    logic capture;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_issue;
    logic pipe_busy;
  } status_t;

endpackage

@@ src/pcm_ctrl.sv @@
module pcm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             mode_i,
  input  pcm_pkg::status_t status_i,
  output pcm_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  pcm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != pcm_pkg::ST_IDLE);
    done_o  = 1'b0;
    case (state_q)
      pcm_pkg::ST_IDLE: begin
        if (start_i) begin
          if (mode_i == pcm_pkg::MODE_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d = status_i.count_zero ? pcm_pkg::ST_DRAIN : pcm_pkg::ST_SEARCH;
          end
        end
      end
      pcm_pkg::ST_SEARCH: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_issue) begin
          state_d = pcm_pkg::ST_DRAIN;
        end
      end
      pcm_pkg::ST_DRAIN: begin
        // The result is final once the compare pipeline has emptied.
        if (!status_i.pipe_busy) begin
          done_o  = 1'b1;
          state_d = pcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pcm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/pcm_datapath.sv @@
module pcm_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pcm_pkg::cmd_t                cmd_i,
  output pcm_pkg::status_t             status_o,
  input  logic                         cfg_we_i,
  input  logic [pcm_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  logic [7:0]                   entry_index_i,
  input  logic [pcm_pkg::COLOR_W-1:0]  blue_i,
  input  logic [pcm_pkg::COLOR_W-1:0]  green_i,
  input  logic [pcm_pkg::COLOR_W-1:0]  red_i,
  output logic [7:0]                   palette_index_o
);

  localparam int unsigned CW = pcm_pkg::COLOR_W;

  // Palette memory, packed as red, green, blue.
  logic [pcm_pkg::ENTRY_W-1:0] mem [pcm_pkg::PALETTE_DEPTH];

  logic [pcm_pkg::COUNT_W-1:0] color_count_q;
  logic [pcm_pkg::COUNT_W-1:0] limit_q;
  logic [pcm_pkg::COUNT_W-1:0] limit_d;
  logic [pcm_pkg::COUNT_W-1:0] addr_q;
  logic [CW-1:0]               pix_b_q, pix_g_q, pix_r_q;

  logic                        v1_q, v2_q;
  logic [pcm_pkg::IDX_W-1:0]   idx1_q, idx2_q;
  logic [pcm_pkg::ENTRY_W-1:0] rdata_q;
  logic [pcm_pkg::SQ_W-1:0]    sq_b_q, sq_g_q, sq_r_q;
  logic [pcm_pkg::SQ_W-1:0]    sq_b_d, sq_g_d, sq_r_d;
  logic [pcm_pkg::DIST_W-1:0]  entry_dist;
  logic [pcm_pkg::DIST_W-1:0]  best_dist_q;
  logic [pcm_pkg::IDX_W-1:0]   best_idx_q;
  logic                        load_in_range;

  function automatic logic [pcm_pkg::SQ_W-1:0] sq_diff(input logic [CW-1:0] a,
                                                       input logic [CW-1:0] b);
    logic [CW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return pcm_pkg::SQ_W'(d) * pcm_pkg::SQ_W'(d);
  endfunction

  assign load_in_range = (pcm_pkg::COUNT_W'(entry_index_i) <
                          pcm_pkg::COUNT_W'(pcm_pkg::PALETTE_DEPTH));

  // Counts beyond the palette saturate to its depth.
  assign limit_d = (color_count_q > pcm_pkg::COUNT_W'(pcm_pkg::PALETTE_DEPTH)) ?
                   pcm_pkg::COUNT_W'(pcm_pkg::PALETTE_DEPTH) : color_count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_in_range) begin
      mem[entry_index_i[pcm_pkg::IDX_W-1:0]] <= {red_i, green_i, blue_i};
    end
    if (cmd_i.issue) begin
      rdata_q <= mem[addr_q[pcm_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_count_q <= pcm_pkg::COUNT_RESET;
      addr_q        <= '0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        color_count_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        addr_q <= '0;
      end else if (cmd_i.issue) begin
        addr_q <= addr_q + pcm_pkg::COUNT_W'(1);
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  assign sq_b_d = sq_diff(rdata_q[CW-1:0], pix_b_q);
  assign sq_g_d = sq_diff(rdata_q[2*CW-1:CW], pix_g_q);
  assign sq_r_d = sq_diff(rdata_q[3*CW-1:2*CW], pix_r_q);

  assign entry_dist = pcm_pkg::DIST_W'(sq_b_q) + pcm_pkg::DIST_W'(sq_g_q) +
                      pcm_pkg::DIST_W'(sq_r_q);

  always_ff @(posedge clk_i) begin
    idx1_q <= addr_q[pcm_pkg::IDX_W-1:0];
    idx2_q <= idx1_q;
    sq_b_q <= sq_b_d;
    sq_g_q <= sq_g_d;
    sq_r_q <= sq_r_d;
    if (cmd_i.capture) begin
      pix_b_q     <= blue_i;
      pix_g_q     <= green_i;
      pix_r_q     <= red_i;
      limit_q     <= limit_d;
      best_idx_q  <= '0;
      best_dist_q <= pcm_pkg::DIST_START;
    end else if (v2_q && (entry_dist < best_dist_q)) begin
      // Strict compare keeps the lowest index on a tie.
      best_idx_q  <= idx2_q;
      best_dist_q <= entry_dist;
    end
  end

  assign status_o.count_zero = (color_count_q == '0);
  assign status_o.last_issue = (addr_q == (limit_q - pcm_pkg::COUNT_W'(1)));
  assign status_o.pipe_busy  = v1_q | v2_q;

  assign palette_index_o = 8'(best_idx_q);

endmodule

@@ src/nearest_palette_color_mapper_unit.sv @@
// Nearest palette colour mapper. A request with mode_i low writes one palette
// entry in the cycle it is accepted and gives no result; busy_o stays low, so
// a new request may follow in the very next cycle. A request with mode_i high
// searches entries 0 to color_count-1 (saturated to the palette depth) for the
// smallest squared distance to the pixel, one entry read from the palette
// memory per cycle, and returns the lowest index among equal distances. The
// search rate is set by the single read port of the palette memory. done_o
// pulses once the compare pipeline has emptied, and the next request can be
// accepted in the cycle after that pulse. With a colour count of zero the
// search is skipped and the result is index 0. The receiver cannot stall:
// palette_index_o is valid only in the single cycle in which done_o is high
// and must be taken then. The user must write the colour count through
// cfg_we_i only while the block is idle, which the block does not enforce.
// Palette entries that were never loaded must not be searched.
module nearest_palette_color_mapper_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          mode_i,
  input  logic [7:0]                    entry_index_i,
  input  logic [pcm_pkg::COLOR_W-1:0]   blue_i,
  input  logic [pcm_pkg::COLOR_W-1:0]   green_i,
  input  logic [pcm_pkg::COLOR_W-1:0]   red_i,
  input  logic                          cfg_we_i,
  input  logic [pcm_pkg::COUNT_W-1:0]   cfg_wdata_i,
  output logic                          done_o,
  output logic [7:0]                    palette_index_o
);

  pcm_pkg::cmd_t    cmd;
  pcm_pkg::status_t status;

  // The controller sequences the read addresses and waits for the
  // compare pipeline to empty before it raises the strobe.
  pcm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .mode_i   (mode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // The datapath holds the palette memory, the colour count register and
  // the read, square and compare stages.
  pcm_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .entry_index_i   (entry_index_i),
    .blue_i          (blue_i),
    .green_i         (green_i),
    .red_i           (red_i),
    .palette_index_o (palette_index_o)
  );

endmodule
